### sv/stq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

    // sizes
    localparam int SLOTS_DEF = 32;
    localparam int TICK_W    = 32;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 80;

    // register reset and saturation value
    localparam logic [TICK_W-1:0] FREQ_RESET = 32'd19200000;
    localparam logic [TICK_W-1:0] TICK_MAX   = 32'hffffffff;

    // opcodes
    localparam logic [1:0] OP_ADD_SEC  = 2'd0;
    localparam logic [1:0] OP_ADD_RATE = 2'd1;
    localparam logic [1:0] OP_ELAPSE   = 2'd2;
    localparam logic [1:0] OP_EXPIRE   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_ZERO_RATE = 2'd3;

    // sequencer states, one-hot
    typedef enum logic [19:0] {
        S_IDLE    = 20'h00001,
        S_MUL     = 20'h00002,
        S_SAT     = 20'h00004,
        S_DIV     = 20'h00008,
        S_ADDW    = 20'h00010,
        S_INS_CHK = 20'h00020,
        S_INS_RD  = 20'h00040,
        S_INS_RT  = 20'h00080,
        S_INS_CMP = 20'h00100,
        S_EL_RUN  = 20'h00200,
        S_EL_END  = 20'h00400,
        S_EX_RD   = 20'h00800,
        S_EX_TAG  = 20'h01000,
        S_EX_CAP  = 20'h02000,
        S_EX_SH   = 20'h04000,
        S_EX_END  = 20'h08000,
        S_HEAD    = 20'h10000,
        S_HEAD_B  = 20'h20000,
        S_HEAD_C  = 20'h40000,
        S_DONE    = 20'h80000
    } state_t;

endpackage

`default_nettype wire

### sv/stq_div.sv
`timescale 1ns / 1ps
`default_nettype none

module stq_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [stq_pkg::TICK_W-1:0] dividend,
    input  wire logic [stq_pkg::TICK_W-1:0] divisor,
    output logic                           done,
    output logic [stq_pkg::TICK_W-1:0]     quotient
);
    import stq_pkg::*;

    localparam int CNT_W = $clog2(TICK_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TICK_W-1:0] rem_reg, rem_next;
    logic [TICK_W-1:0] quo_reg, quo_next;
    logic [TICK_W-1:0] div_reg, div_next;
    logic [TICK_W:0]   shifted;
    logic              fits;

    // one restoring step per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[TICK_W-1]};
        fits      = shifted >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? TICK_W'(shifted - {1'b0, div_reg}) : shifted[TICK_W-1:0];
            quo_next = {quo_reg[TICK_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(TICK_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            div_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            div_reg  <= div_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### sv/sorted_timer_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted timer queue: a pool of SLOTS timer slots whose entries live in three
// synchronous-read memories (remaining ticks, tag, sorted order list),
// walked by a sequencer one entry at a time. One item is processed at a time;
// a new item is taken while the previous result waits on the output register.
// An add after seconds multiplies by the tick frequency and saturates; an add
// at rate runs the serial divider. Either add then walks the order list from
// its tail, moving back each entry holding more remaining ticks than the new
// one. Elapse walks all SLOTS slots; expire removes the head and shifts the
// pending entries one place forward. The result beat is registered as the
// sequencer returns to idle; a stalled result holds the sequencer in its last
// state until the previous beat is taken. Each memory has a single read port,
// and the divider takes one step per cycle. Opcode travels on s_tuser,
// operand and tag on s_tdata.
module sorted_timer_queue #(
    parameter int SLOTS = stq_pkg::SLOTS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [stq_pkg::TICK_W-1:0]   cfg_data,     // tick_frequency
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [stq_pkg::S_TDATA_W-1:0] s_tdata,     // operand, tag
    input  wire logic [1:0]                   s_tuser,      // opcode
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // status, slot, expired_tag, is_new_head, head_valid, head_remaining, zero pad
    output logic [stq_pkg::M_TDATA_W-1:0]     m_tdata
);
    import stq_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // memories
    logic [IW-1:0]     ord_mem [SLOTS];
    logic [TICK_W-1:0] rem_mem [SLOTS];
    logic [TICK_W-1:0] tag_mem [SLOTS];

    logic              ord_we, rem_we, tag_we;
    logic [IW-1:0]     ord_waddr, ord_raddr, rem_waddr, rem_raddr, tag_raddr;
    logic [IW-1:0]     ord_wdata;
    logic [TICK_W-1:0] rem_wdata;
    logic [IW-1:0]     ord_rdata_reg;
    logic [TICK_W-1:0] rem_rdata_reg, tag_rdata_reg;

    // control and payload registers
    state_t                 state_reg, state_next;
    logic [TICK_W-1:0]      freq_reg, freq_next;
    logic [SLOTS-1:0]       free_reg, free_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [TICK_W-1:0]      operand_reg, operand_next;
    logic [TICK_W-1:0]      tag_reg, tag_next;
    logic [IW-1:0]          slot_reg, slot_next;
    logic [IW-1:0]          k_reg, k_next;
    logic [IW-1:0]          cnt_reg, cnt_next;
    logic [IW-1:0]          moved_reg, moved_next;
    logic [IW-1:0]          pipe_addr_reg, pipe_addr_next;
    logic                   el_v_reg, el_v_next;
    logic                   sh_v_reg, sh_v_next;
    logic [2*TICK_W-1:0]    prod_reg, prod_next;
    logic [TICK_W-1:0]      ticks_reg, ticks_next;
    logic [1:0]             status_reg, status_next;
    logic [TICK_W-1:0]      etag_reg, etag_next;
    logic                   newhead_reg, newhead_next;
    logic                   hv_reg, hv_next;
    logic [TICK_W-1:0]      hrem_reg, hrem_next;
    logic                   mvalid_reg, mvalid_next;
    logic [M_TDATA_W-1:0]   mdata_reg, mdata_next;

    logic [IW-1:0]     low_free;
    logic [4:0]        slot_out;
    logic [TICK_W-1:0] in_operand, in_tag;
    logic              div_start;
    logic              div_done;
    logic [TICK_W-1:0] div_q;

    assign in_operand = s_tdata[TICK_W-1:0];
    assign in_tag     = s_tdata[2*TICK_W-1:TICK_W];
    assign slot_out   = 5'(slot_reg);
    assign cfg_ready  = 1'b1;
    assign s_tready   = state_reg == S_IDLE;
    assign m_tvalid   = mvalid_reg;
    assign m_tdata    = mdata_reg;

    // lowest free slot
    always_comb
    begin
        low_free = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
                low_free = IW'(i);
        end
    end

    // serial divider for add at rate
    stq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (freq_reg),
        .divisor  (operand_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // memory ports
    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_waddr] <= ord_wdata;
        ord_rdata_reg <= ord_mem[ord_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rem_we)
            rem_mem[rem_waddr] <= rem_wdata;
        rem_rdata_reg <= rem_mem[rem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[slot_reg] <= tag_reg;
        tag_rdata_reg <= tag_mem[tag_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        freq_next      = cfg_valid ? cfg_data : freq_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        operand_next   = operand_reg;
        tag_next       = tag_reg;
        slot_next      = slot_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        moved_next     = moved_reg;
        pipe_addr_next = cnt_reg;
        el_v_next      = state_reg == S_EL_RUN;
        sh_v_next      = state_reg == S_EX_SH;
        prod_next      = prod_reg;
        ticks_next     = ticks_reg;
        status_next    = status_reg;
        etag_next      = etag_reg;
        newhead_next   = newhead_reg;
        hv_next        = hv_reg;
        hrem_next      = hrem_reg;
        mvalid_next    = mvalid_reg & ~m_tready;
        mdata_next     = mdata_reg;
        div_start      = 1'b0;
        ord_we         = 1'b0;
        ord_waddr      = '0;
        ord_wdata      = slot_reg;
        ord_raddr      = '0;
        rem_we         = 1'b0;
        rem_waddr      = slot_reg;
        rem_wdata      = ticks_reg;
        rem_raddr      = '0;
        tag_we         = 1'b0;
        tag_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    operand_next = in_operand;
                    tag_next     = in_tag;
                    status_next  = ST_OK;
                    etag_next    = '0;
                    newhead_next = 1'b0;
                    slot_next    = '0;
                    cnt_next     = '0;
                    unique case (s_tuser)
                        OP_ADD_SEC, OP_ADD_RATE:
                        begin
                            if (free_reg == '0)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_HEAD;
                            end
                            else if (s_tuser == OP_ADD_RATE && in_operand == '0)
                            begin
                                status_next = ST_ZERO_RATE;
                                state_next  = S_HEAD;
                            end
                            else
                            begin
                                slot_next           = low_free;
                                free_next[low_free] = 1'b0;
                                state_next = (s_tuser == OP_ADD_SEC) ? S_MUL : S_DIV;
                            end
                        end
                        OP_ELAPSE:
                            state_next = S_EL_RUN;
                        OP_EXPIRE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_HEAD;
                            end
                            else
                                state_next = S_EX_RD;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next  = (2*TICK_W)'(operand_reg) * (2*TICK_W)'(freq_reg);
                state_next = S_SAT;
            end
            S_SAT:
            begin
                ticks_next = (prod_reg[2*TICK_W-1:TICK_W] != '0) ? TICK_MAX
                                                                 : prod_reg[TICK_W-1:0];
                state_next = S_ADDW;
            end
            S_DIV:
            begin
                // start pulse on first cycle only; a later start would restart a busy divider
                div_start = !sh_v_reg && !el_v_reg && (cnt_reg == '0);
                cnt_next  = IW'(1);
                if (div_done)
                begin
                    ticks_next = div_q;
                    state_next = S_ADDW;
                end
            end
            S_ADDW:
            begin
                rem_we     = 1'b1;
                tag_we     = 1'b1;
                k_next     = count_reg[IW-1:0];
                state_next = S_INS_CHK;
            end
            S_INS_CHK:
            begin
                if (k_reg == '0)
                begin
                    ord_we       = 1'b1;
                    ord_waddr    = '0;
                    newhead_next = 1'b1;
                    count_next   = count_reg + 1'b1;
                    state_next   = S_HEAD;
                end
                else
                    state_next = S_INS_RD;
            end
            S_INS_RD:
            begin
                ord_raddr  = k_reg - 1'b1;
                state_next = S_INS_RT;
            end
            S_INS_RT:
            begin
                rem_raddr  = ord_rdata_reg;
                moved_next = ord_rdata_reg;
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                // later entries with more ticks move one place back
                ord_we    = 1'b1;
                ord_waddr = k_reg;
                if (rem_rdata_reg > ticks_reg)
                begin
                    ord_wdata  = moved_reg;
                    k_next     = k_reg - 1'b1;
                    state_next = S_INS_CHK;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_EL_RUN:
            begin
                rem_raddr = cnt_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == IW'(SLOTS - 1))
                    state_next = S_EL_END;
            end
            S_EL_END:
                state_next = S_HEAD;
            S_EX_RD:
            begin
                ord_raddr  = '0;
                state_next = S_EX_TAG;
            end
            S_EX_TAG:
            begin
                tag_raddr                = ord_rdata_reg;
                slot_next                = ord_rdata_reg;
                free_next[ord_rdata_reg] = 1'b1;
                state_next               = S_EX_CAP;
            end
            S_EX_CAP:
            begin
                etag_next  = tag_rdata_reg;
                cnt_next   = IW'(1);
                state_next = (count_reg == CW'(1)) ? S_EX_END : S_EX_SH;
            end
            S_EX_SH:
            begin
                ord_raddr = cnt_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == IW'(count_reg - CW'(1)))
                    state_next = S_EX_END;
            end
            S_EX_END:
            begin
                count_next = count_reg - 1'b1;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                if (count_reg == '0)
                begin
                    hv_next    = 1'b0;
                    hrem_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    ord_raddr  = '0;
                    state_next = S_HEAD_B;
                end
            end
            S_HEAD_B:
            begin
                rem_raddr  = ord_rdata_reg;
                state_next = S_HEAD_C;
            end
            S_HEAD_C:
            begin
                hv_next    = 1'b1;
                hrem_next  = rem_rdata_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = M_TDATA_W'({hrem_reg, hv_reg, newhead_reg,
                                              etag_reg, slot_out, status_reg});
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        // elapse write-back, in the cycle after its read
        if (el_v_reg && !free_reg[pipe_addr_reg])
        begin
            rem_we    = 1'b1;
            rem_waddr = pipe_addr_reg;
            rem_wdata = (rem_rdata_reg > operand_reg) ? rem_rdata_reg - operand_reg : '0;
        end

        // expire shift, entry moves one place forward
        if (sh_v_reg)
        begin
            ord_we    = 1'b1;
            ord_waddr = pipe_addr_reg - 1'b1;
            ord_wdata = ord_rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            freq_reg      <= FREQ_RESET;
            free_reg      <= '1;
            count_reg     <= '0;
            operand_reg   <= '0;
            tag_reg       <= '0;
            slot_reg      <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            moved_reg     <= '0;
            pipe_addr_reg <= '0;
            el_v_reg      <= 1'b0;
            sh_v_reg      <= 1'b0;
            prod_reg      <= '0;
            ticks_reg     <= '0;
            status_reg    <= ST_OK;
            etag_reg      <= '0;
            newhead_reg   <= 1'b0;
            hv_reg        <= 1'b0;
            hrem_reg      <= '0;
            mvalid_reg    <= 1'b0;
            mdata_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            freq_reg      <= freq_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            operand_reg   <= operand_next;
            tag_reg       <= tag_next;
            slot_reg      <= slot_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            moved_reg     <= moved_next;
            pipe_addr_reg <= pipe_addr_next;
            el_v_reg      <= el_v_next;
            sh_v_reg      <= sh_v_next;
            prod_reg      <= prod_next;
            ticks_reg     <= ticks_next;
            status_reg    <= status_next;
            etag_reg      <= etag_next;
            newhead_reg   <= newhead_next;
            hv_reg        <= hv_next;
            hrem_reg      <= hrem_next;
            mvalid_reg    <= mvalid_next;
            mdata_reg     <= mdata_next;
        end
    end

endmodule

`default_nettype wire

### sv/stq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module stq_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [stq_pkg::M_TDATA_W-1:0] m_tdata
);
    import stq_pkg::*;

    logic [1:0]        status;
    logic [4:0]        slot;
    logic [TICK_W-1:0] etag;
    logic              newhead;
    logic              hvalid;
    logic [TICK_W-1:0] hrem;

    assign status  = m_tdata[1:0];
    assign slot    = m_tdata[6:2];
    assign etag    = m_tdata[38:7];
    assign newhead = m_tdata[39];
    assign hvalid  = m_tdata[40];
    assign hrem    = m_tdata[72:41];

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // empty queue leaves nothing behind
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status == ST_EMPTY |-> !hvalid && slot == 5'd0 && etag == '0)
        else $error("empty expire reported an entry");

    // a new head implies a successful add
    a_newhead: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && newhead |-> status == ST_OK && hvalid && etag == '0)
        else $error("new head without a successful add");

    // no head means zero remaining
    a_nohead: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !hvalid |-> hrem == '0)
        else $error("head remaining set with empty queue");

    // full pool keeps its entries
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status == ST_FULL |-> hvalid && !newhead && slot == 5'd0)
        else $error("pool full reported with empty queue");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
